/* rtl/core/ale_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// ale_pkg
// Shared sizes, request codes and transfer types of the array list engine.
// ============================================================================
package ale_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((LEN_W > 8) ? LEN_W : 8) + 1;

    localparam logic [2:0] MODE_INSERT   = 3'd0;
    localparam logic [2:0] MODE_DELETE   = 3'd1;
    localparam logic [2:0] MODE_GET      = 3'd2;
    localparam logic [2:0] MODE_LOCATE   = 3'd3;
    localparam logic [2:0] MODE_EXCHANGE = 3'd4;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         position;
        logic signed [31:0] element_value;
        logic [7:0]         first_len;
        logic [7:0]         second_len;
    } ale_cmd_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         list_length_out;
    } ale_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ale_status_t;

endpackage

/* rtl/core/ale_req_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// ale_req_if
// Request channel of the array list engine: valid, ready and request fields.
// ============================================================================
interface ale_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [7:0]         position;
    logic signed [31:0] element_value;
    logic [7:0]         first_len;
    logic [7:0]         second_len;

    modport source (
        output valid, mode, position, element_value, first_len, second_len,
        input  ready
    );

    modport sink (
        input  valid, mode, position, element_value, first_len, second_len,
        output ready
    );
endinterface

/* rtl/core/ale_rsp_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// ale_rsp_if
// Response channel of the array list engine: valid, ready and result fields.
// ============================================================================
interface ale_rsp_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         list_length_out;

    modport source (
        output valid, ok, read_value, found_position, list_length_out,
        input  ready
    );

    modport sink (
        input  valid, ok, read_value, found_position, list_length_out,
        output ready
    );
endinterface

/* rtl/core/array_list_engine_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// array_list_engine_top
// Ordered list of signed 32-bit elements with insert, delete, get, locate
// and leading-block exchange, one response per request.
// ============================================================================
// Requests arrive on req and each produces exactly one transfer on rsp.
// A request is taken only while the sequencer is idle, so one request is in
// work at a time; the next one may be taken while a response still waits
// in the output register.
// The element store has one read and one write port with registered read
// data, and every element moved or compared takes a read step and then a
// write or compare step. Exchange is done as three in-place reversals, one
// swapped pair at a time; a rejected request goes straight to the finish state.
// Reset empties the list at once; the store itself is not cleared, since
// only entries below the current length are ever read.
// When the receiver stalls, the response holds in the output register and
// a finished request waits in the sequencer until that register drains.
// ============================================================================
module array_list_engine_top (
    input logic      clk,
    input logic      rst_n,
    ale_req_if.sink  req,
    ale_rsp_if.source rsp
);

    ale_pkg::ale_cmd_t    cmd;
    ale_pkg::ale_res_t    res;
    ale_pkg::ale_status_t status;
    logic                 res_ready;
    logic                 out_valid_reg;
    ale_pkg::ale_res_t    out_reg;

    assign cmd.mode          = req.mode;
    assign cmd.position      = req.position;
    assign cmd.element_value = req.element_value;
    assign cmd.first_len     = req.first_len;
    assign cmd.second_len    = req.second_len;

    assign req.ready = status.idle;
    assign res_ready = !out_valid_reg || rsp.ready;

    ale_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid && req.ready),
        .cmd       (cmd),
        .res_ready (res_ready),
        .status    (status),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (status.done && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.ok              = out_reg.ok;
    assign rsp.read_value      = out_reg.read_value;
    assign rsp.found_position  = out_reg.found_position;
    assign rsp.list_length_out = out_reg.list_length_out;

endmodule

/* rtl/core/ale_engine.sv */
`timescale 1ns / 1ps
// ============================================================================
// ale_engine
// Sequencer and element store: shifts, scans and reversals one entry a step.
// ============================================================================
module ale_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ale_pkg::ale_cmd_t    cmd,
    input  logic                 res_ready,
    output ale_pkg::ale_status_t status,
    output ale_pkg::ale_res_t    res
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_DEL_RD,
        ST_DEL_CAP,
        ST_DEL_SRD,
        ST_DEL_SWR,
        ST_GET_RD,
        ST_GET_CAP,
        ST_LOC_RD,
        ST_LOC_CMP,
        ST_SW_INIT,
        ST_SW_RA,
        ST_SW_RB,
        ST_SW_WA,
        ST_SW_WB,
        ST_FINISH
    } state_t;

    state_t                    state_reg;
    ale_pkg::ale_cmd_t         cmd_reg;
    ale_pkg::len_t             len_reg;
    ale_pkg::len_t             idx_reg;
    ale_pkg::addr_t            lo_reg;
    ale_pkg::addr_t            hi_reg;
    logic [1:0]                phase_reg;
    logic signed [31:0]        tmp_reg;
    logic                      ok_reg;
    logic signed [31:0]        rd_reg;
    ale_pkg::len_t             found_reg;

    logic signed [31:0]        mem [ale_pkg::CAPACITY];
    logic signed [31:0]        rdata_reg;

    logic                      rd_en;
    ale_pkg::addr_t            rd_addr;
    logic                      wr_en;
    ale_pkg::addr_t            wr_addr;
    logic signed [31:0]        wr_data;

    logic [ale_pkg::CMP_W-1:0] new_pos_w;
    logic [ale_pkg::CMP_W-1:0] new_len_w;
    logic [ale_pkg::CMP_W-1:0] new_mn_w;
    logic [ale_pkg::CMP_W-1:0] pos_w;
    logic [ale_pkg::CMP_W-1:0] m_w;
    logic [ale_pkg::CMP_W-1:0] mn_w;
    ale_pkg::len_t             idx_m1;
    ale_pkg::len_t             idx_p1;
    logic [7:0]                pos_m1;

    assign new_pos_w = ale_pkg::CMP_W'(cmd.position);
    assign new_len_w = ale_pkg::CMP_W'(len_reg);
    assign new_mn_w  = ale_pkg::CMP_W'(cmd.first_len) + ale_pkg::CMP_W'(cmd.second_len);
    assign pos_w     = ale_pkg::CMP_W'(cmd_reg.position);
    assign m_w       = ale_pkg::CMP_W'(cmd_reg.first_len);
    assign mn_w      = m_w + ale_pkg::CMP_W'(cmd_reg.second_len);
    assign idx_m1    = idx_reg - 1'b1;
    assign idx_p1    = idx_reg + 1'b1;
    assign pos_m1    = cmd_reg.position - 8'd1;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rdata_reg;
        unique case (state_reg)
            ST_INS_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ale_pkg::ADDR_W'(idx_m1);
            end
            ST_INS_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = ale_pkg::ADDR_W'(idx_reg);
            end
            ST_INS_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = ale_pkg::ADDR_W'(pos_m1);
                wr_data = cmd_reg.element_value;
            end
            ST_DEL_RD, ST_GET_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ale_pkg::ADDR_W'(pos_m1);
            end
            ST_DEL_SRD, ST_LOC_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ale_pkg::ADDR_W'(idx_reg);
            end
            ST_DEL_SWR:
            begin
                wr_en   = 1'b1;
                wr_addr = ale_pkg::ADDR_W'(idx_m1);
            end
            ST_SW_RA:
            begin
                rd_en   = (lo_reg < hi_reg);
                rd_addr = lo_reg;
            end
            ST_SW_RB:
            begin
                rd_en   = 1'b1;
                rd_addr = hi_reg;
            end
            ST_SW_WA:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
            end
            ST_SW_WB:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        ok_reg    <= 1'b0;
                        rd_reg    <= ale_pkg::INT_MIN;
                        found_reg <= '0;
                        phase_reg <= 2'd0;
                        unique case (cmd.mode)
                            ale_pkg::MODE_INSERT:
                            begin
                                idx_reg <= len_reg;
                                if (new_pos_w >= 1 && new_pos_w <= new_len_w + 1'b1
                                    && new_len_w < ale_pkg::CMP_W'(ale_pkg::CAPACITY))
                                begin
                                    state_reg <= (new_len_w >= new_pos_w) ? ST_INS_RD
                                                                          : ST_INS_PUT;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            ale_pkg::MODE_DELETE, ale_pkg::MODE_GET:
                            begin
                                idx_reg <= ale_pkg::LEN_W'(cmd.position);
                                if (new_pos_w >= 1 && new_pos_w <= new_len_w)
                                begin
                                    state_reg <= (cmd.mode == ale_pkg::MODE_DELETE)
                                                 ? ST_DEL_RD : ST_GET_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            ale_pkg::MODE_LOCATE:
                            begin
                                idx_reg   <= '0;
                                state_reg <= (len_reg != '0) ? ST_LOC_RD : ST_FINISH;
                            end
                            ale_pkg::MODE_EXCHANGE:
                            begin
                                if (len_reg != '0 && cmd.first_len != 8'd0
                                    && cmd.second_len != 8'd0 && new_mn_w <= new_len_w)
                                begin
                                    state_reg <= ST_SW_INIT;
                                end
                                else
                                begin
                                    state_reg <= ST_FINISH;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end
                ST_INS_RD:
                begin
                    state_reg <= ST_INS_WR;
                end
                ST_INS_WR:
                begin
                    idx_reg   <= idx_m1;
                    state_reg <= (ale_pkg::CMP_W'(idx_m1) >= pos_w) ? ST_INS_RD : ST_INS_PUT;
                end
                ST_INS_PUT:
                begin
                    len_reg   <= len_reg + 1'b1;
                    ok_reg    <= 1'b1;
                    state_reg <= ST_FINISH;
                end
                ST_DEL_RD:
                begin
                    state_reg <= ST_DEL_CAP;
                end
                ST_DEL_CAP:
                begin
                    rd_reg <= rdata_reg;
                    if (idx_reg < len_reg)
                    begin
                        state_reg <= ST_DEL_SRD;
                    end
                    else
                    begin
                        len_reg   <= len_reg - 1'b1;
                        ok_reg    <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DEL_SRD:
                begin
                    state_reg <= ST_DEL_SWR;
                end
                ST_DEL_SWR:
                begin
                    idx_reg <= idx_p1;
                    if (idx_p1 < len_reg)
                    begin
                        state_reg <= ST_DEL_SRD;
                    end
                    else
                    begin
                        len_reg   <= len_reg - 1'b1;
                        ok_reg    <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_GET_RD:
                begin
                    state_reg <= ST_GET_CAP;
                end
                ST_GET_CAP:
                begin
                    rd_reg    <= rdata_reg;
                    ok_reg    <= 1'b1;
                    state_reg <= ST_FINISH;
                end
                ST_LOC_RD:
                begin
                    state_reg <= ST_LOC_CMP;
                end
                ST_LOC_CMP:
                begin
                    idx_reg <= idx_p1;
                    if (rdata_reg == cmd_reg.element_value)
                    begin
                        found_reg <= idx_p1;
                        ok_reg    <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= (idx_p1 < len_reg) ? ST_LOC_RD : ST_FINISH;
                    end
                end
                ST_SW_INIT:
                begin
                    unique case (phase_reg)
                        2'd0:
                        begin
                            lo_reg    <= '0;
                            hi_reg    <= ale_pkg::ADDR_W'(m_w - 1'b1);
                            state_reg <= ST_SW_RA;
                        end
                        2'd1:
                        begin
                            lo_reg    <= ale_pkg::ADDR_W'(m_w);
                            hi_reg    <= ale_pkg::ADDR_W'(mn_w - 1'b1);
                            state_reg <= ST_SW_RA;
                        end
                        2'd2:
                        begin
                            lo_reg    <= '0;
                            hi_reg    <= ale_pkg::ADDR_W'(mn_w - 1'b1);
                            state_reg <= ST_SW_RA;
                        end
                        default:
                        begin
                            ok_reg    <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                    endcase
                end
                ST_SW_RA:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= ST_SW_RB;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        state_reg <= ST_SW_INIT;
                    end
                end
                ST_SW_RB:
                begin
                    tmp_reg   <= rdata_reg;
                    state_reg <= ST_SW_WA;
                end
                ST_SW_WA:
                begin
                    state_reg <= ST_SW_WB;
                end
                ST_SW_WB:
                begin
                    lo_reg    <= lo_reg + 1'b1;
                    hi_reg    <= hi_reg - 1'b1;
                    state_reg <= ST_SW_RA;
                end
                ST_FINISH:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.idle          = (state_reg == ST_IDLE);
    assign status.done          = (state_reg == ST_FINISH);
    assign res.ok               = ok_reg;
    assign res.read_value       = rd_reg;
    assign res.found_position   = 8'(found_reg);
    assign res.list_length_out  = 8'(len_reg);

endmodule

/* rtl/core/ale_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// ale_checker
// Port-level checks of the array list engine, bound to the top level.
// ============================================================================
module ale_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_ok,
    input logic signed [31:0] rsp_read_value,
    input logic [7:0]         rsp_found_position,
    input logic [7:0]         rsp_list_length_out
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
            && $stable(rsp_read_value) && $stable(rsp_found_position)
            && $stable(rsp_list_length_out))
        else $error("Stalled response changed.");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request taken while the previous one was still in work.");

    a_reject_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_read_value == ale_pkg::INT_MIN
            && rsp_found_position == 8'd0)
        else $error("Rejected request returned data.");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found_position != 8'd0 |-> rsp_ok
            && rsp_read_value == ale_pkg::INT_MIN)
        else $error("Locate hit with inconsistent fields.");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ale_pkg::CAPACITY > 255
            || int'(rsp_list_length_out) <= ale_pkg::CAPACITY)
        else $error("List length above capacity.");

endmodule

bind array_list_engine_top ale_checker u_ale_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_ok              (rsp.ok),
    .rsp_read_value      (rsp.read_value),
    .rsp_found_position  (rsp.found_position),
    .rsp_list_length_out (rsp.list_length_out)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the array list engine.
// ============================================================================
// A queue of requests is built at time zero and fed to the request channel
// by a clocked driver. Each accepted request is run through a behavioral
// copy of the list, and the predicted response is stored. A clocked monitor
// compares every response transfer with the oldest prediction. Both channels
// stall at random, the response side holds off once for a long stretch, and
// the request side twice waits until the engine has drained.
// ============================================================================
module testbench;
    import ale_pkg::*;

    localparam logic [2:0] MODE_RESERVED_A = 3'd5;
    localparam logic [2:0] MODE_RESERVED_B = 3'd6;
    localparam logic [2:0] MODE_RESERVED_C = 3'd7;

    localparam logic signed [31:0] MAX_ELEMENT = 32'sh7fff_ffff;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 1200;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM   = 700;
    localparam int CALM_TO     = 850;

    typedef struct {
        ale_cmd_t cmd;
        bit       drain;
    } backlog_entry_t;

    logic clk;
    logic rst_n;

    ale_req_if req_ch ();
    ale_rsp_if rsp_ch ();

    array_list_engine_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    backlog_entry_t     request_backlog[$];
    backlog_entry_t     next_entry;
    ale_res_t           predicted_results[$];
    ale_res_t           wanted;
    ale_cmd_t           accepted_cmd;
    logic signed [31:0] list_image[$];

    int gen_len      = 0;
    int taken_count  = 0;
    int done_count   = 0;
    int fail_count   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 0;
    bit send_now;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("Mismatch: %s", what);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        end
        else if (r < 55)
        begin
            return INT_MIN;
        end
        else if (r < 60)
        begin
            return MAX_ELEMENT;
        end
        return $signed($urandom());
    endfunction

    function automatic void enqueue_request(input logic [2:0] mode, input int pos,
                                            input logic signed [31:0] value,
                                            input int m, input int n, input bit drain);
        backlog_entry_t e;
        e.cmd.mode          = mode;
        e.cmd.position      = 8'(pos);
        e.cmd.element_value = value;
        e.cmd.first_len     = 8'(m);
        e.cmd.second_len    = 8'(n);
        e.drain             = drain;
        if (mode == MODE_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
        begin
            gen_len++;
        end
        else if (mode == MODE_DELETE && pos >= 1 && pos <= gen_len)
        begin
            gen_len--;
        end
        request_backlog.push_back(e);
    endfunction

    function automatic void add_random_requests(input int count, input bit drain_first);
        int r;
        int k;
        int ins_w;
        int pos;
        int m;
        int n;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            pos = $urandom_range(0, 255);
            m = $urandom_range(0, 255);
            n = $urandom_range(0, 255);
            if (r < 12)
            begin
                enqueue_request(3'($urandom_range(0, 7)), pos, $signed($urandom()), m, n,
                                drain_first && i == 0);
            end
            else
            begin
                k = $urandom_range(0, 99);
                ins_w = (gen_len < 12) ? 50 : ((gen_len > 40) ? 15 : 30);
                if (k < ins_w)
                begin
                    pos = $urandom_range(1, gen_len + 1);
                    enqueue_request(MODE_INSERT, pos, pick_value(), m, n, drain_first && i == 0);
                end
                else if (k < ins_w + 35)
                begin
                    pos = (gen_len == 0) ? 1 : $urandom_range(1, gen_len);
                    enqueue_request((k < ins_w + 20) ? MODE_DELETE : MODE_GET, pos,
                                    $signed($urandom()), m, n, drain_first && i == 0);
                end
                else if (k < ins_w + 52)
                begin
                    enqueue_request(MODE_LOCATE, pos, pick_value(), m, n, drain_first && i == 0);
                end
                else
                begin
                    m = 1;
                    n = 1;
                    if (gen_len >= 2)
                    begin
                        m = $urandom_range(1, gen_len - 1);
                        n = $urandom_range(1, gen_len - m);
                    end
                    enqueue_request(MODE_EXCHANGE, pos, $signed($urandom()), m, n,
                                    drain_first && i == 0);
                end
            end
        end
    endfunction

    function automatic ale_res_t apply_request(input ale_cmd_t c);
        ale_res_t           r;
        int                 len;
        int                 p;
        int                 m;
        int                 n;
        logic signed [31:0] head[$];
        r.ok             = 1'b0;
        r.read_value     = INT_MIN;
        r.found_position = '0;
        len = list_image.size();
        p = c.position;
        m = c.first_len;
        n = c.second_len;
        case (c.mode)
            MODE_INSERT:
            begin
                if (p >= 1 && p <= len + 1 && len < CAPACITY)
                begin
                    list_image.insert(p - 1, c.element_value);
                    r.ok = 1'b1;
                end
            end
            MODE_DELETE:
            begin
                if (p >= 1 && p <= len)
                begin
                    r.read_value = list_image[p - 1];
                    list_image.delete(p - 1);
                    r.ok = 1'b1;
                end
            end
            MODE_GET:
            begin
                if (p >= 1 && p <= len)
                begin
                    r.read_value = list_image[p - 1];
                    r.ok = 1'b1;
                end
            end
            MODE_LOCATE:
            begin
                for (int i = 0; i < len; i++)
                begin
                    if (!r.ok && list_image[i] == c.element_value)
                    begin
                        r.found_position = 8'(i + 1);
                        r.ok = 1'b1;
                    end
                end
            end
            MODE_EXCHANGE:
            begin
                if (len != 0 && m != 0 && n != 0 && m + n <= len)
                begin
                    // The second block moves to the front, the first block follows it.
                    for (int i = 0; i < m; i++)
                    begin
                        head.push_back(list_image[i]);
                    end
                    for (int i = 0; i < n; i++)
                    begin
                        list_image[i] = list_image[m + i];
                    end
                    for (int i = 0; i < m; i++)
                    begin
                        list_image[n + i] = head[i];
                    end
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.list_length_out = 8'(list_image.size());
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_ch.ready))
        begin
            send_now = request_backlog.size() != 0;
            if (send_now && request_backlog[0].drain
                && (req_ch.valid || taken_count != done_count))
            begin
                send_now = 1'b0;
            end
            if (send_now && !(taken_count >= CALM_FROM && taken_count < CALM_TO)
                && $urandom_range(0, 99) < 36)
            begin
                send_now = 1'b0;
            end
            if (send_now)
            begin
                next_entry = request_backlog.pop_front();
                req_ch.valid         <= 1'b1;
                req_ch.mode          <= next_entry.cmd.mode;
                req_ch.position      <= next_entry.cmd.position;
                req_ch.element_value <= next_entry.cmd.element_value;
                req_ch.first_len     <= next_entry.cmd.first_len;
                req_ch.second_len    <= next_entry.cmd.second_len;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            accepted_cmd.mode          = req_ch.mode;
            accepted_cmd.position      = req_ch.position;
            accepted_cmd.element_value = req_ch.element_value;
            accepted_cmd.first_len     = req_ch.first_len;
            accepted_cmd.second_len    = req_ch.second_len;
            predicted_results.push_back(apply_request(accepted_cmd));
            taken_count <= taken_count + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && taken_count >= HOLD_AT)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            rsp_ch.ready <= (done_count >= CALM_FROM && done_count < CALM_TO)
                            || $urandom_range(0, 99) >= 36;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (predicted_results.size() == 0)
            begin
                note_failure($sformatf("response with nothing outstanding: ok=%0b read=%0d",
                                       rsp_ch.ok, rsp_ch.read_value));
            end
            else
            begin
                wanted = predicted_results.pop_front();
                if (rsp_ch.ok !== wanted.ok || rsp_ch.read_value !== wanted.read_value
                    || rsp_ch.found_position !== wanted.found_position
                    || rsp_ch.list_length_out !== wanted.list_length_out)
                begin
                    note_failure($sformatf(
                        "response %0d expected ok=%0b read=%0d found=%0d len=%0d, got ok=%0b read=%0d found=%0d len=%0d",
                        done_count, wanted.ok, wanted.read_value, wanted.found_position,
                        wanted.list_length_out, rsp_ch.ok, rsp_ch.read_value,
                        rsp_ch.found_position, rsp_ch.list_length_out));
                end
            end
            done_count <= done_count + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_INSERT;
        req_ch.position      = '0;
        req_ch.element_value = '0;
        req_ch.first_len     = '0;
        req_ch.second_len    = '0;
        rsp_ch.ready         = 1'b0;

        // Requests against an empty list, then a small list of extreme values.
        enqueue_request(MODE_GET, 1, 0, 0, 0, 0);
        enqueue_request(MODE_DELETE, 1, 0, 0, 0, 0);
        enqueue_request(MODE_LOCATE, 0, 0, 0, 0, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, 1, 1, 0);
        enqueue_request(MODE_INSERT, 0, 5, 0, 0, 0);
        enqueue_request(MODE_INSERT, 2, 5, 0, 0, 0);
        enqueue_request(MODE_INSERT, 1, INT_MIN, 0, 0, 0);
        enqueue_request(MODE_INSERT, 2, MAX_ELEMENT, 0, 0, 0);
        enqueue_request(MODE_INSERT, 1, 0, 0, 0, 0);
        enqueue_request(MODE_INSERT, 3, -1, 0, 0, 0);
        enqueue_request(MODE_GET, 4, 0, 0, 0, 0);
        enqueue_request(MODE_GET, 5, 0, 0, 0, 0);
        enqueue_request(MODE_GET, 255, 0, 0, 0, 0);
        enqueue_request(MODE_LOCATE, 0, MAX_ELEMENT, 0, 0, 0);
        enqueue_request(MODE_LOCATE, 0, 7, 0, 0, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, 0, 2, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, 2, 0, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, 3, 2, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, 255, 255, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, 1, 3, 0);
        enqueue_request(MODE_RESERVED_A, 1, 0, 1, 1, 0);
        enqueue_request(MODE_RESERVED_B, 1, 0, 1, 1, 0);
        enqueue_request(MODE_RESERVED_C, 1, 0, 1, 1, 0);
        enqueue_request(MODE_DELETE, 0, 0, 0, 0, 0);
        enqueue_request(MODE_DELETE, 5, 0, 0, 0, 0);
        enqueue_request(MODE_DELETE, 4, 0, 0, 0, 0);

        add_random_requests(330, 1);

        // Fill the list to capacity, work on the full list, then shrink it.
        enqueue_request(MODE_GET, 1, 0, 0, 0, 1);
        while (gen_len < CAPACITY)
        begin
            enqueue_request(MODE_INSERT, $urandom_range(1, gen_len + 1), pick_value(),
                            $urandom_range(0, 255), $urandom_range(0, 255), 0);
        end
        enqueue_request(MODE_INSERT, 1, 9, 0, 0, 0);
        enqueue_request(MODE_INSERT, CAPACITY + 1, 9, 0, 0, 0);
        enqueue_request(MODE_GET, CAPACITY, 0, 0, 0, 0);
        enqueue_request(MODE_GET, CAPACITY + 1, 0, 0, 0, 0);
        enqueue_request(MODE_LOCATE, 0, $signed($urandom()), 0, 0, 0);
        enqueue_request(MODE_LOCATE, 0, pick_value(), 0, 0, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, 1, CAPACITY - 1, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, CAPACITY / 2, CAPACITY / 2, 0);
        enqueue_request(MODE_EXCHANGE, 0, 0, CAPACITY / 2, CAPACITY / 2 + 1, 0);
        enqueue_request(MODE_DELETE, CAPACITY, 0, 0, 0, 0);
        enqueue_request(MODE_INSERT, CAPACITY, MAX_ELEMENT, 0, 0, 0);
        enqueue_request(MODE_DELETE, 1, 0, 0, 0, 0);
        while (gen_len > 16)
        begin
            enqueue_request(MODE_DELETE, $urandom_range(1, gen_len), $signed($urandom()),
                            $urandom_range(0, 255), $urandom_range(0, 255), 0);
        end

        add_random_requests(400, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (done_count != taken_count)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predicted_results.size() != 0)
        begin
            note_failure($sformatf("%0d responses never arrived", predicted_results.size()));
        end
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/ale_pkg.sv
rtl/core/ale_req_if.sv
rtl/core/ale_rsp_if.sv
rtl/core/ale_engine.sv
rtl/core/array_list_engine_top.sv
rtl/core/ale_checker.sv
bench/testbench.sv
